/* hdl/mcet_pkg.sv */
// Shared field widths, item layout and operation codes for the echo timer.
package mcet_pkg;

   // Input item fields
   localparam int OP_W   = 2;
   localparam int PINS_W = 6;
   localparam int ARM_W  = 3;

   // Result item fields
   localparam int CHAN_W = 3;
   localparam int TIME_W = 16;

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_ARM    = 2'd2
   } op_type;

endpackage

/* hdl/multi_channel_echo_timer.sv */
// Multi-channel echo timer: top level with input register, state and result register.
// A result passes through the input register and then the result register.
// Throughput: one item per cycle; the pick and state update are one shallow pass.
// A held result stalls the input register only when the consumer is not ready.
// Reset (synchronous, active high) clears the timer, saved pins, armed and ranging
// bits and both valid flags; no clearing pass is needed.
module multi_channel_echo_timer #(
   parameter int CHANNELS   = 6,
   parameter int TIMER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mcet_pkg::REQ_DATA_W-1:0]    req_tdata,  // echo_pins[5:0], arm_channel[8:6]
   input  logic [mcet_pkg::OP_W-1:0]          req_tuser,  // op[1:0]
   // Result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mcet_pkg::RSP_DATA_W-1:0]    rsp_tdata   // channel[2:0], echo_time[18:3]
);
   import mcet_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PAD_W = RSP_DATA_W - CHAN_W - TIME_W;

   // ---------------- input register ----------------
   logic                  in_valid_ff, in_valid_in;
   logic [OP_W-1:0]       in_op_ff;
   logic [PINS_W-1:0]     in_pins_ff;
   logic [ARM_W-1:0]      in_arm_ff;

   // ---------------- block state ----------------
   logic [CHANNELS-1:0]   last_pins_ff, last_pins_in;
   logic [CHANNELS-1:0]   armed_ff, armed_in;
   logic [CHANNELS-1:0]   ranging_ff, ranging_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;

   // ---------------- result register ----------------
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]     rsp_chan_ff;
   logic [TIME_W-1:0]     rsp_time_ff;

   logic                  advance;   // result slot free this cycle
   logic                  in_take;   // item in the input register is processed
   logic                  is_sample;
   logic                  emit;      // capture reported
   logic                  start;     // armed channel starts ranging
   logic [CHANNELS-1:0]   pins_ch;
   logic [CHANNELS+PINS_W-1:0] pins_ext;
   logic [CHANNELS-1:0]   diff;
   logic                  found;
   logic [CHANNELS-1:0]   pick_bit;
   logic [IDX_W-1:0]      pick_idx;
   logic [CHANNELS-1:0]   arm_mask;

   // Handshake: the input register drains whenever the result slot can take a new item.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign in_take    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_pins_ff <= req_tdata[PINS_W-1:0];
         in_arm_ff  <= req_tdata[PINS_W+ARM_W-1:PINS_W];
      end
   end

   // Pins above the channel count are dropped; channels from six up see a zero pin.
   assign pins_ext = {{CHANNELS{1'b0}}, in_pins_ff};
   assign pins_ch  = pins_ext[CHANNELS-1:0];
   assign diff     = pins_ch ^ last_pins_ff;

   mcet_pick #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_pick (
      .diff     (diff),
      .found    (found),
      .pick_bit (pick_bit),
      .pick_idx (pick_idx)
   );

   // Arm decode; an out-of-range channel matches no bit.
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         arm_mask[i] = (32'(in_arm_ff) == i);
      end
   end

   assign is_sample = (in_op_ff == OP_SAMPLE);
   assign emit      = in_take && is_sample && found && |(ranging_ff & pick_bit);
   assign start     = in_take && is_sample && found && |(armed_ff & pick_bit);

   // State update: capture first, then a restart of the same channel.
   always_comb begin
      last_pins_in = last_pins_ff;
      armed_in     = armed_ff;
      ranging_in   = ranging_ff;
      timer_in     = timer_ff;
      if (in_take) begin
         case (in_op_ff)
            OP_TICK: begin
               timer_in = timer_ff + TIMER_BITS'(1);
            end
            OP_ARM: begin
               armed_in = armed_ff | arm_mask;
            end
            OP_SAMPLE: begin
               last_pins_in = pins_ch;
               if (emit) begin
                  ranging_in = ranging_ff & ~pick_bit;
               end
               if (start) begin
                  timer_in   = '0;
                  armed_in   = armed_ff & ~pick_bit;
                  ranging_in = ranging_in | pick_bit;
               end
            end
            default: begin
               // unused op: no effect
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pins_ff <= '0;
         armed_ff     <= '0;
         ranging_ff   <= '0;
         timer_ff     <= '0;
      end else begin
         last_pins_ff <= last_pins_in;
         armed_ff     <= armed_in;
         ranging_ff   <= ranging_in;
         timer_ff     <= timer_in;
      end
   end

   // Result register: loads on a capture, empties when the consumer takes the item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_chan_ff <= CHAN_W'(pick_idx);
         rsp_time_ff <= TIME_W'(timer_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_time_ff, rsp_chan_ff};

   // ---------------- assertions ----------------
   // A capture never overwrites a result still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten while pending");

   // A reported channel stops ranging unless it was armed for a restart.
   a_capture_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && !start) |=> ((ranging_ff & $past(pick_bit)) == '0))
      else $error("ranging bit not cleared after capture");

   // A restart clears the shared timer and leaves the channel ranging.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      start |=> (timer_ff == '0) && ((ranging_ff & $past(pick_bit)) != '0))
      else $error("restart did not clear timer or set ranging");

endmodule

/* hdl/mcet_pick.sv */
// Lowest-set-bit picker: finds the lowest-numbered channel whose pin changed.
module mcet_pick #(
   parameter int CHANNELS = 6,
   parameter int IDX_W    = 3
) (
   input  logic [CHANNELS-1:0] diff,
   output logic                found,
   output logic [CHANNELS-1:0] pick_bit,
   output logic [IDX_W-1:0]    pick_idx
);

   // Isolate the lowest set bit with two's complement
   assign pick_bit = diff & (~diff + CHANNELS'(1));
   assign found    = |diff;

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (pick_bit[i]) begin
            pick_idx = pick_idx | IDX_W'(i);
         end
      end
   end

endmodule

/* dv/echo_capture_checker.sv */
// Echo timer checker: predicts echo captures from input items and compares result items.
module echo_capture_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mcet_pkg::REQ_DATA_W-1:0] req_tdata,   // echo_pins[5:0], arm_channel[8:6]
   input  logic [mcet_pkg::OP_W-1:0]       req_tuser,   // op[1:0]
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [mcet_pkg::RSP_DATA_W-1:0] rsp_tdata,   // channel[2:0], echo_time[18:3]
   output int                              mismatches,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import mcet_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [TIME_W-1:0] echo_time;
   } capture_type;

   capture_type       capture_q[$];
   logic [PINS_W-1:0] saved_pins;
   logic [PINS_W-1:0] armed_mask;
   logic [PINS_W-1:0] ranging_mask;
   logic [TIME_W-1:0] shared_timer;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
   endtask

   // Lowest changed pin wins; a capture is reported before a re-arm restarts the channel.
   task automatic advance_echo_state(input logic [OP_W-1:0] op, input logic [PINS_W-1:0] pins,
                                     input logic [ARM_W-1:0] arm_chan);
      logic [PINS_W-1:0] changed;
      int                first;
      capture_type       cap;
      first = -1;
      case (op)
         OP_TICK: begin
            shared_timer = shared_timer + 1'b1;
         end
         OP_ARM: begin
            if (arm_chan < PINS_W) armed_mask[arm_chan] = 1'b1;
         end
         OP_SAMPLE: begin
            changed = pins ^ saved_pins;
            for (int n = PINS_W - 1; n >= 0; n--) begin
               if (changed[n]) first = n;
            end
            if (first >= 0) begin
               if (ranging_mask[first]) begin
                  cap.channel   = CHAN_W'(first);
                  cap.echo_time = shared_timer;
                  capture_q.push_back(cap);
                  ranging_mask[first] = 1'b0;
               end
               if (armed_mask[first]) begin
                  shared_timer        = '0;
                  armed_mask[first]   = 1'b0;
                  ranging_mask[first] = 1'b1;
               end
            end
            saved_pins = pins;
         end
         default: begin
            // reserved op: no effect
         end
      endcase
   endtask

   always @(posedge clock) begin
      capture_type  want;
      capture_type  got;
      if (reset) begin
         saved_pins   = '0;
         armed_mask   = '0;
         ranging_mask = '0;
         shared_timer = '0;
         capture_q.delete();
      end else begin
         // results first: any result at this edge belongs to an older item
         if (rsp_tvalid && rsp_tready) begin
            got.channel   = rsp_tdata[CHAN_W-1:0];
            got.echo_time = rsp_tdata[CHAN_W+TIME_W-1:CHAN_W];
            if (capture_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result: channel %0d echo_time %0d",
                                         got.channel, got.echo_time));
            end else begin
               want = capture_q.pop_front();
               if (got.channel !== want.channel || got.echo_time !== want.echo_time) begin
                  report_mismatch($sformatf(
                     "expected channel %0d echo_time %0d, got channel %0d echo_time %0d",
                     want.channel, want.echo_time, got.channel, got.echo_time));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            advance_echo_state(req_tuser, req_tdata[PINS_W-1:0],
                               req_tdata[PINS_W+ARM_W-1:PINS_W]);
         end
      end
      pending = capture_q.size();
   end

endmodule

/* dv/testbench.sv */
// Top of the echo timer testbench: clock, reset, item stimulus, idling and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mcet_pkg::*;

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;   // unused op code
   localparam int RANDOM_ITEMS  = 500;
   localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
   localparam int STALL_LIMIT   = 4000;    // cycles with no item moving on either side
   localparam int DRAIN_CYCLES  = 10;      // result passes the input and result registers after accept; margin

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int                    mismatches;
   int                    pending;
   int                    idle_run = 0;
   int                    items_sent = 0;
   logic [PINS_W-1:0]     pin_level = '0;      // pins last sent on a sample item
   bit                    quiet = 1'b0;        // no idling on either side while set
   bit                    hold_request = 1'b0;
   bit                    hold_done = 1'b0;

   always #1 clock = ~clock;

   multi_channel_echo_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   echo_capture_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Gap length: often none, mostly short, now and then long.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item and hold it until accepted. Leaves time at the falling edge
   // after the accepting edge so the next call can keep tvalid high.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [PINS_W-1:0] pins,
                            input logic [ARM_W-1:0] arm_chan);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - PINS_W - ARM_W){1'b0}}, arm_chan, pins};
      do @(posedge clock); while (!req_tready);
      if (op == OP_SAMPLE) pin_level = pins;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic tick_run(input int count);
      repeat (count) send_item(OP_TICK, PINS_W'($urandom), ARM_W'($urandom));
   endtask

   // Sample that flips channel chan and possibly higher pins, so chan is the one handled.
   task automatic flip_channel(input int chan);
      logic [PINS_W-1:0] above;
      above = PINS_W'($urandom) & ~((PINS_W'(2) << chan) - PINS_W'(1));
      send_item(OP_SAMPLE, pin_level ^ (PINS_W'(1) << chan) ^ above, ARM_W'($urandom));
   endtask

   // Any op, any pins, any channel code - including reserved op and out-of-range arms.
   task automatic noise_item();
      send_item(OP_W'($urandom), PINS_W'($urandom), ARM_W'($urandom));
   endtask

   // Arm, start edge, some ticks, end edge. Sometimes broken: arm skipped or noise in between.
   task automatic echo_sequence(input int chan);
      if ($urandom_range(0, 9) != 0) send_item(OP_ARM, PINS_W'($urandom), ARM_W'(chan));
      if ($urandom_range(0, 3) == 0) noise_item();
      flip_channel(chan);
      if ($urandom_range(0, 19) == 0) tick_run($urandom_range(20, 100));
      else tick_run($urandom_range(0, 6));
      if ($urandom_range(0, 3) == 0) noise_item();
      // re-arm before the end edge: capture then immediate restart
      if ($urandom_range(0, 4) == 0) send_item(OP_ARM, PINS_W'($urandom), ARM_W'(chan));
      flip_channel(chan);
   endtask

   // Receiver: ready bursts with random gaps, plus one long hold-off on request.
   initial begin : rsp_side
      int gap;
      forever begin
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
            gap = idle_cycles();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   end

   // Watchdog on item movement.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin : stimulus
      int start_count;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      // reserved op with every data bit set; out-of-range arms
      send_item(OP_RESERVED, '1, '1);
      send_item(OP_ARM, '0, 3'd6);
      send_item(OP_ARM, '1, 3'd7);
      // no pin changed: nothing happens
      send_item(OP_SAMPLE, '0, '0);
      // unarmed edge on channel 0: saved, no result
      send_item(OP_SAMPLE, 6'h01, '0);
      send_item(OP_ARM, '0, 3'd0);
      // start edge on channel 0, then samples that leave channel 0 alone
      send_item(OP_SAMPLE, 6'h00, '0);
      send_item(OP_SAMPLE, 6'h00, '0);
      send_item(OP_SAMPLE, 6'h3E, '0);
      // end edge with no ticks: echo_time zero (samples do not tick)
      send_item(OP_SAMPLE, 6'h3F, '0);
      // channel 5: start, three ticks, re-arm, end edge reports then restarts
      send_item(OP_ARM, '0, 3'd5);
      send_item(OP_SAMPLE, 6'h1F, '0);
      tick_run(3);
      send_item(OP_ARM, '0, 3'd5);
      send_item(OP_SAMPLE, 6'h3F, '0);
      tick_run(1);
      send_item(OP_SAMPLE, 6'h1F, '0);

      // shared timer: channel 3's start clears it again, so channel 2 ends on 60 and channel 3 on 62
      quiet = 1'b1;
      send_item(OP_ARM, '0, 3'd2);
      flip_channel(2);
      send_item(OP_ARM, '0, 3'd3);
      flip_channel(3);
      tick_run(60);
      flip_channel(2);
      tick_run(2);
      flip_channel(3);
      quiet = 1'b0;

      // --- pressure: receiver holds off while result-making items keep coming ---
      hold_request = 1'b1;
      repeat (10) echo_sequence($urandom_range(0, PINS_W - 1));

      // --- random ---
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 8) quiet = ~quiet;   // runs with and without idling
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) noise_item();
         end else begin
            echo_sequence($urandom_range(0, PINS_W - 1));
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      // drain
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
